@@ src/drt_pkg.sv @@
package drt_pkg;

    localparam int CHANNELS = 3;

    localparam int DEBOUNCE_W = 8;
    localparam int HOLD_W     = 16;
    localparam int DIVIDE_W   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // item kinds
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_TICK   = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_TIME      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TICK_DIVIDE    = 2'd2;

    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_COUNT_RST = 8'd10;
    localparam logic [HOLD_W-1:0]     HOLD_TIME_RST      = 16'd5;
    localparam logic [DIVIDE_W-1:0]   TICK_DIVIDE_RST    = 16'd500;

    typedef struct packed {
        logic                kind;
        logic [CHANNELS-1:0] pin_levels;
    } in_item_t;

    typedef struct packed {
        logic [CHANNELS-1:0] output_flags;
        logic [CHANNELS-1:0] debounced_levels;
        logic                heartbeat;
        logic                lamp;
    } out_item_t;

    typedef struct packed {
        logic sample;
        logic tick;
    } lane_ctrl_t;

    typedef struct packed {
        logic level;
        logic active;
    } lane_stat_t;

    typedef struct packed {
        logic div_tick;
        logic heartbeat_next;
    } tick_stat_t;

endpackage

@@ src/debounced_retrigger_hold_timer_unit.sv @@
// Debounce and retriggerable hold timer for three active-low pins. Each input
// item is either a pin sample or a base timer tick and yields exactly one result
// item holding the state after the update. All channel lanes and the tick
// divider update in the cycle of acceptance and the merged result is registered,
// so the block takes one item per clock while the output buffer is not full. A
// two-entry output buffer keeps s_ready registered and lets one more item in
// while a result waits on m_ready. Configuration writes on cfg_* are always
// taken; an index past the register list is ignored.
module debounced_retrigger_hold_timer_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  drt_pkg::in_item_t               s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output drt_pkg::out_item_t              m_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [drt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [drt_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import drt_pkg::*;

    logic [DEBOUNCE_W-1:0] debounce_count_reg;
    logic [HOLD_W-1:0]     hold_time_reg;
    logic [DIVIDE_W-1:0]   tick_divide_reg;

    logic                  accept;
    lane_ctrl_t            lane_ctrl;
    lane_stat_t            lane_stat [CHANNELS];
    tick_stat_t            tick_st;
    logic                  lamp_reg, lamp_next;
    out_item_t             result;

    out_item_t             main_reg, skid_reg;
    logic                  main_valid_reg, skid_valid_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_count_reg <= DEBOUNCE_COUNT_RST;
            hold_time_reg      <= HOLD_TIME_RST;
            tick_divide_reg    <= TICK_DIVIDE_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_DEBOUNCE_COUNT: debounce_count_reg <= cfg_data[DEBOUNCE_W-1:0];
                REG_HOLD_TIME:      hold_time_reg      <= cfg_data[HOLD_W-1:0];
                REG_TICK_DIVIDE:    tick_divide_reg    <= cfg_data[DIVIDE_W-1:0];
                default: ;
            endcase
        end
    end

    assign accept = s_valid & s_ready;

    drt_tick u_tick (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .tick_en     (accept && s_data.kind == KIND_TICK),
        .tick_divide (tick_divide_reg),
        .stat        (tick_st)
    );

    assign lane_ctrl.sample = accept && s_data.kind == KIND_SAMPLE;
    assign lane_ctrl.tick   = tick_st.div_tick;

    for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_lane
        drt_lane u_lane (
            .aclk           (aclk),
            .aresetn        (aresetn),
            .ctrl           (lane_ctrl),
            .raw            (s_data.pin_levels[ch]),
            .debounce_count (debounce_count_reg),
            .hold_time      (hold_time_reg),
            .stat_next      (lane_stat[ch])
        );
    end

    // merge lane results into one result item
    assign lamp_next = tick_st.div_tick ? lane_stat[0].active : lamp_reg;

    always_comb begin
        for (int ch = 0; ch < CHANNELS; ch++) begin
            result.output_flags[ch]     = lane_stat[ch].active;
            result.debounced_levels[ch] = lane_stat[ch].level;
        end
        result.heartbeat = tick_st.heartbeat_next;
        result.lamp      = lamp_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lamp_reg <= 1'b0;
        end else begin
            lamp_reg <= lamp_next;
        end
    end

    // output register with one skid entry
    assign s_ready = ~skid_valid_reg;
    assign m_valid = main_valid_reg;
    assign m_data  = main_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (accept) begin
            if (!main_valid_reg || m_ready) begin
                main_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (main_valid_reg && m_ready) begin
            main_valid_reg <= skid_valid_reg;
            skid_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            if (!main_valid_reg || m_ready) begin
                main_reg <= result;
            end else begin
                skid_reg <= result;
            end
        end else if (main_valid_reg && m_ready && skid_valid_reg) begin
            main_reg <= skid_reg;
        end
    end

    a_skid_needs_main: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid entry held without a main entry");

    a_pressed_is_active: assert property (@(posedge aclk) disable iff (!aresetn)
        lane_ctrl.sample |=> &(m_valid ? (m_data.output_flags | m_data.debounced_levels)
                                       : {CHANNELS{1'b1}}) || skid_valid_reg)
        else $error("pressed channel not active after sample");

    a_heartbeat_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !tick_st.div_tick |=> tick_st.heartbeat_next == $past(tick_st.heartbeat_next)
                              || tick_st.div_tick)
        else $error("heartbeat moved without a divided tick");

    a_lamp_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !tick_st.div_tick |=> lamp_reg == $past(lamp_reg))
        else $error("lamp changed without a divided tick");

    a_no_accept_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_valid_reg && !(m_valid && m_ready)) |=> skid_valid_reg)
        else $error("stalled skid entry lost");

endmodule

@@ src/drt_lane.sv @@
module drt_lane (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  drt_pkg::lane_ctrl_t             ctrl,
    input  logic                            raw,
    input  logic [drt_pkg::DEBOUNCE_W-1:0]  debounce_count,
    input  logic [drt_pkg::HOLD_W-1:0]      hold_time,
    output drt_pkg::lane_stat_t             stat_next
);
    import drt_pkg::*;

    logic                  level_reg, level_next;
    logic [DEBOUNCE_W-1:0] cnt_reg, cnt_next;
    logic                  active_reg, active_next;
    logic [HOLD_W-1:0]     hold_reg, hold_next;
    logic [DEBOUNCE_W-1:0] cnt_inc;
    logic [HOLD_W-1:0]     hold_dec;

    assign cnt_inc  = cnt_reg + 1'b1;
    assign hold_dec = hold_reg - 1'b1;

    always_comb begin
        level_next  = level_reg;
        cnt_next    = cnt_reg;
        active_next = active_reg;
        hold_next   = hold_reg;
        if (ctrl.sample) begin
            if (level_reg != raw) begin
                if (cnt_inc >= debounce_count) begin
                    cnt_next   = '0;
                    level_next = raw;
                end else begin
                    cnt_next = cnt_inc;
                end
            end else begin
                cnt_next = '0;
            end
            // pressed channel retriggers its hold
            if (!level_next) begin
                active_next = 1'b1;
                hold_next   = hold_time;
            end
        end else if (ctrl.tick && active_reg) begin
            hold_next = hold_dec;
            if (hold_dec == '0) begin
                active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg  <= 1'b1;
            cnt_reg    <= '0;
            active_reg <= 1'b0;
            hold_reg   <= '0;
        end else begin
            level_reg  <= level_next;
            cnt_reg    <= cnt_next;
            active_reg <= active_next;
            hold_reg   <= hold_next;
        end
    end

    assign stat_next.level  = level_next;
    assign stat_next.active = active_next;

endmodule

@@ src/drt_tick.sv @@
module drt_tick (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          tick_en,
    input  logic [drt_pkg::DIVIDE_W-1:0]  tick_divide,
    output drt_pkg::tick_stat_t           stat
);
    import drt_pkg::*;

    logic [DIVIDE_W-1:0] presc_reg, presc_next;
    logic                heartbeat_reg, heartbeat_next;
    logic [DIVIDE_W:0]   presc_inc;
    logic                wrap;

    assign presc_inc = {1'b0, presc_reg} + 1'b1;
    // a zero divide acts as one since the incremented count is never below it
    assign wrap      = presc_inc >= {1'b0, tick_divide};

    always_comb begin
        presc_next     = presc_reg;
        heartbeat_next = heartbeat_reg;
        if (tick_en) begin
            if (wrap) begin
                presc_next     = '0;
                heartbeat_next = ~heartbeat_reg;
            end else begin
                presc_next = presc_inc[DIVIDE_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            presc_reg     <= '0;
            heartbeat_reg <= 1'b0;
        end else begin
            presc_reg     <= presc_next;
            heartbeat_reg <= heartbeat_next;
        end
    end

    assign stat.div_tick       = tick_en & wrap;
    assign stat.heartbeat_next = heartbeat_next;

endmodule
